[hw/rtl/tmf_pkg.sv]
// Shared types and constants for the trimmed-mean converter channel filter.
package tmf_pkg;

	// Block configuration.
	localparam int NUM_SAMPLES  = 8;
	localparam int NUM_CHANNELS = 4;

	// Field and state widths.
	localparam int CH_W  = 2;
	localparam int SMP_W = 12;
	localparam int SUM_W = 18;
	localparam int CNT_W = 6;
	localparam int LIM_W = 12;
	localparam int REF_W = 13;
	localparam int MV_W  = 14;
	localparam int AVG_W = 12;

	// Configuration port.
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SPREAD_LIMIT = 2'd0,
		CFG_REF_MV       = 2'd1
	} cfg_reg_t;

	localparam logic [LIM_W-1:0] SPREAD_LIMIT_RST = 12'd200;
	localparam logic [REF_W-1:0] REF_MV_RST       = 13'd3300;
	localparam logic signed [MV_W-1:0] ERROR_MV   = -14'sd1000;

	// Divide the trimmed sum by the number of kept samples: multiply by a
	// rounded-up reciprocal, exact for any sum below 2**SUM_W.
	localparam int DIV_D   = NUM_SAMPLES - 2;
	localparam int DIV_K   = SUM_W + 6;
	localparam int DIV_M_W = DIV_K + 1;
	localparam longint unsigned DIV_M_L = ((64'd1 << DIV_K) + 64'(DIV_D) - 64'd1) / 64'(DIV_D);
	localparam logic [DIV_M_W-1:0] DIV_M = DIV_M_L[DIV_M_W-1:0];

	// Divide avg * ref_mv by full scale with the same reciprocal scheme.
	localparam int FULL_SCALE = 4095;
	localparam int PROD_W     = AVG_W + REF_W;
	localparam int FS_K       = PROD_W + 12;
	localparam int FS_M_W     = 26;
	localparam longint unsigned FS_M_L =
		((64'd1 << FS_K) + 64'(FULL_SCALE) - 64'd1) / 64'(FULL_SCALE);
	localparam logic [FS_M_W-1:0] FS_M = FS_M_L[FS_M_W-1:0];

	// A completed window handed from the accumulator to the scaling pipeline.
	typedef struct packed {
		logic             done;
		logic [CH_W-1:0]  ch;
		logic             err;
		logic [SUM_W-1:0] trimmed;
	} win_t;

endpackage

[hw/rtl/tmf_accum.sv]
// Per-channel window state: count, running sum, minimum and maximum.
module tmf_accum import tmf_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             take,
	input  logic [CH_W-1:0]  ch,
	input  logic [SMP_W-1:0] smp,
	input  logic [LIM_W-1:0] spread_limit,
	output win_t             win
);

	logic [CNT_W-1:0] count_q [NUM_CHANNELS];
	logic [SUM_W-1:0] sum_q   [NUM_CHANNELS];
	logic [SMP_W-1:0] min_q   [NUM_CHANNELS];
	logic [SMP_W-1:0] max_q   [NUM_CHANNELS];

	logic             ch_ok;
	logic             first;
	logic [CNT_W-1:0] cnt_n;
	logic             last;
	logic [SUM_W-1:0] sum_n;
	logic [SMP_W-1:0] min_n;
	logic [SMP_W-1:0] max_n;
	logic [SMP_W-1:0] spread;

	// Fold the sample into the channel's window.
	always_comb begin
		ch_ok  = 32'(ch) < 32'(NUM_CHANNELS);
		first  = count_q[ch] == '0;
		cnt_n  = count_q[ch] + CNT_W'(1);
		last   = cnt_n == CNT_W'(NUM_SAMPLES);
		sum_n  = first ? SUM_W'(smp) : sum_q[ch] + SUM_W'(smp);
		min_n  = (first || smp < min_q[ch]) ? smp : min_q[ch];
		max_n  = (first || smp > max_q[ch]) ? smp : max_q[ch];
		spread = max_n - min_n;
		win.done    = ch_ok && last;
		win.ch      = ch;
		win.err     = spread > spread_limit;
		win.trimmed = sum_n - SUM_W'(max_n) - SUM_W'(min_n);
	end

	// Sample counters restart at zero after reset and after each window.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				count_q[i] <= '0;
			end
		end else if (take && ch_ok) begin
			count_q[ch] <= last ? '0 : cnt_n;
		end
	end

	// Sum and extremes are loaded by a window's first sample.
	always_ff @(posedge clk) begin
		if (take && ch_ok) begin
			sum_q[ch] <= sum_n;
			min_q[ch] <= min_n;
			max_q[ch] <= max_n;
		end
	end

endmodule

[hw/rtl/tmf_scale.sv]
// Pipeline that turns a completed window into a millivolt result.
module tmf_scale import tmf_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   win_valid,
	input  win_t                   win,
	output logic                   win_ready,
	input  logic [REF_W-1:0]       ref_mv,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [CH_W-1:0]        result_channel,
	output logic signed [MV_W-1:0] value_mv,
	output logic                   spread_error
);

	logic                   v_s2, v_s3, v_s4, out_valid_q;
	logic [CH_W-1:0]        ch_s2, ch_s3, ch_s4, ch_q;
	logic                   err_s2, err_s3, err_s4, err_q;
	logic [SUM_W-1:0]       trimmed_s2;
	logic [AVG_W-1:0]       avg_s3;
	logic [PROD_W-1:0]      prod_s4;
	logic signed [MV_W-1:0] mv_q;

	logic                        rdy_out, rdy_s4, rdy_s3, rdy_s2;
	logic [SUM_W+DIV_M_W-1:0]    div_prod;
	logic [PROD_W+FS_M_W-1:0]    fs_prod;
	logic [REF_W-1:0]            mv_mag;

	// A stage may load when it is empty or its contents move on.
	always_comb begin
		rdy_out = !out_valid_q || !out_stall;
		rdy_s4  = !v_s4 || rdy_out;
		rdy_s3  = !v_s3 || rdy_s4;
		rdy_s2  = !v_s2 || rdy_s3;
	end

	assign win_ready = rdy_s2;

	// Reciprocal multiplies for the two constant divisions.
	always_comb begin
		div_prod = SUM_W'(trimmed_s2) * DIV_M;
		fs_prod  = PROD_W'(prod_s4) * FS_M;
		mv_mag   = fs_prod[FS_K +: REF_W];
	end

	// Valid bits of every stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (rdy_s2) begin
				v_s2 <= win_valid;
			end
			if (rdy_s3) begin
				v_s3 <= v_s2;
			end
			if (rdy_s4) begin
				v_s4 <= v_s3;
			end
			if (rdy_out) begin
				out_valid_q <= v_s4;
			end
		end
	end

	// Payload of every stage.
	always_ff @(posedge clk) begin
		if (rdy_s2 && win_valid) begin
			ch_s2      <= win.ch;
			err_s2     <= win.err;
			trimmed_s2 <= win.trimmed;
		end
		if (rdy_s3 && v_s2) begin
			ch_s3  <= ch_s2;
			err_s3 <= err_s2;
			avg_s3 <= div_prod[DIV_K +: AVG_W];
		end
		if (rdy_s4 && v_s3) begin
			ch_s4   <= ch_s3;
			err_s4  <= err_s3;
			prod_s4 <= PROD_W'(avg_s3) * PROD_W'(ref_mv);
		end
		if (rdy_out && v_s4) begin
			ch_q  <= ch_s4;
			err_q <= err_s4;
			mv_q  <= err_s4 ? ERROR_MV : signed'({1'b0, mv_mag});
		end
	end

	assign out_valid      = out_valid_q;
	assign result_channel = ch_q;
	assign value_mv       = mv_q;
	assign spread_error   = err_q;

endmodule

[hw/rtl/trimmed_mean_adc_channel_filter.sv]
// Top level of the trimmed-mean converter channel filter.
// Path: a window's result moves from the input register through stages s2, s3 and
// s4 to the output register, and a stalled output holds it there.
// Throughput: one sample per cycle while in_stall is low; each stage holds one item,
// and a stalled output fills the stages behind it before in_stall rises.
// Reset clears all valid bits and sample counters and loads the default spread limit and reference.
module trimmed_mean_adc_channel_filter import tmf_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [CH_W-1:0]        channel,
	input  logic [SMP_W-1:0]       sample,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [CH_W-1:0]        result_channel,
	output logic signed [MV_W-1:0] value_mv,
	output logic                   spread_error
);

	logic [LIM_W-1:0] spread_limit_q;
	logic [REF_W-1:0] ref_mv_q;
	logic             v_s1;
	logic [CH_W-1:0]  ch_s1;
	logic [SMP_W-1:0] smp_s1;
	logic             win_ready;
	logic             take;
	win_t             win;

	assign cfg_ready = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spread_limit_q <= SPREAD_LIMIT_RST;
			ref_mv_q       <= REF_MV_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_SPREAD_LIMIT: spread_limit_q <= cfg_data[LIM_W-1:0];
				CFG_REF_MV:       ref_mv_q       <= cfg_data[REF_W-1:0];
				default: ;
			endcase
		end
	end

	// Input register; the sample updates channel state as it leaves.
	assign take     = v_s1 && win_ready;
	assign in_stall = v_s1 && !win_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (!in_stall) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			ch_s1  <= channel;
			smp_s1 <= sample;
		end
	end

	tmf_accum u_accum (
		.clk          (clk),
		.arst_n       (arst_n),
		.take         (take),
		.ch           (ch_s1),
		.smp          (smp_s1),
		.spread_limit (spread_limit_q),
		.win          (win)
	);

	tmf_scale u_scale (
		.clk            (clk),
		.arst_n         (arst_n),
		.win_valid      (v_s1 && win.done),
		.win            (win),
		.win_ready      (win_ready),
		.ref_mv         (ref_mv_q),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.result_channel (result_channel),
		.value_mv       (value_mv),
		.spread_error   (spread_error)
	);

endmodule

[hw/rtl/tmf_checker.sv]
// Port-level checks for the trimmed-mean converter channel filter.
module tmf_checker import tmf_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   in_stall,
	input logic                   out_valid,
	input logic                   out_stall,
	input logic signed [MV_W-1:0] value_mv,
	input logic                   spread_error
);

	// An error result always carries the error value.
	a_err_value: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && spread_error |-> value_mv == ERROR_MV)
		else $error("error result without error value");

	// A good result is never negative.
	a_good_sign: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !spread_error |-> value_mv >= 0)
		else $error("good result is negative");

	// Input backpressure only comes from a full pipeline behind a stalled output.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled while output is free");

	// A stalled result holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(value_mv) && $stable(spread_error))
		else $error("stalled result changed");

endmodule

bind trimmed_mean_adc_channel_filter tmf_checker u_tmf_checker (.*);

[tb/sv/tb_trimmed_mean_adc_channel_filter.sv]
// Self-checking testbench for the trimmed-mean converter channel filter.
module tb_trimmed_mean_adc_channel_filter;
	timeunit 1ns;
	timeprecision 1ps;
	import tmf_pkg::*;

	// Cycles from the accepting edge of a window's last sample to its result.
	localparam int RESULT_LATENCY = 4;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int NUM_PHASES = 6;
	localparam int ITEMS_PER_PHASE = 216;
	localparam int MAX_REPORTS = 10;

	// Register indexes past the end of the register list.
	localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_3 = 2'd3;

	typedef struct packed {
		logic [CH_W-1:0]        ch;
		logic signed [MV_W-1:0] mv;
		logic                   err;
	} mv_result_t;

	typedef enum logic {ROW_SAMPLE, ROW_CFG} row_kind_t;

	typedef struct packed {
		row_kind_t              kind;
		logic [CFG_IDX_W-1:0]   idx;
		logic [CFG_DATA_W-1:0]  data;
		logic [CH_W-1:0]        ch;
		logic [SMP_W-1:0]       smp;
		logic                   typed;
		mv_result_t             want;
	} row_t;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;
	logic                   in_valid;
	logic                   in_stall;
	logic [CH_W-1:0]        channel;
	logic [SMP_W-1:0]       sample;
	logic                   out_valid;
	logic                   out_stall;
	logic [CH_W-1:0]        result_channel;
	logic signed [MV_W-1:0] value_mv;
	logic                   spread_error;

	// Predictor state: per-channel window and the two registers.
	logic [CNT_W-1:0] chan_count [NUM_CHANNELS];
	logic [SUM_W-1:0] chan_sum [NUM_CHANNELS];
	logic [SMP_W-1:0] chan_min [NUM_CHANNELS];
	logic [SMP_W-1:0] chan_max [NUM_CHANNELS];
	logic [LIM_W-1:0] lim_reg;
	logic [REF_W-1:0] ref_reg;

	// Range that the random samples of each channel's current window are drawn from.
	int win_lo [NUM_CHANNELS];
	int win_width [NUM_CHANNELS];

	mv_result_t pending_results [$];
	int mismatch_count = 0;
	int idle_cycles = 0;
	bit no_idle;
	row_t dir_rows [26];

	trimmed_mean_adc_channel_filter u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.channel        (channel),
		.sample         (sample),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.result_channel (result_channel),
		.value_mv       (value_mv),
		.spread_error   (spread_error)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Fold one accepted sample into its channel and work out the window result, if any.
	function automatic void fold_sample(input logic [CH_W-1:0] ch, input logic [SMP_W-1:0] s,
			output bit produced, output mv_result_t res);
		logic [SUM_W-1:0] trimmed;
		longint unsigned avg;
		longint unsigned scaled;
		produced = 1'b0;
		res = '0;
		if (chan_count[ch] == '0) begin
			chan_sum[ch] = SUM_W'(s);
			chan_min[ch] = s;
			chan_max[ch] = s;
		end else begin
			chan_sum[ch] = chan_sum[ch] + SUM_W'(s);
			if (s < chan_min[ch]) chan_min[ch] = s;
			if (s > chan_max[ch]) chan_max[ch] = s;
		end
		chan_count[ch] = chan_count[ch] + 1'b1;
		if (chan_count[ch] < CNT_W'(NUM_SAMPLES)) return;
		chan_count[ch] = '0;
		produced = 1'b1;
		res.ch = ch;
		if (chan_max[ch] - chan_min[ch] > lim_reg) begin
			res.mv = ERROR_MV;
			res.err = 1'b1;
		end else begin
			trimmed = chan_sum[ch] - SUM_W'(chan_max[ch]) - SUM_W'(chan_min[ch]);
			avg = 64'(trimmed) / 64'(NUM_SAMPLES - 2);
			scaled = (avg * 64'(ref_reg)) / 64'(FULL_SCALE);
			res.mv = MV_W'(scaled);
			res.err = 1'b0;
		end
	endfunction

	// Draw the next sample of a channel; a new window picks a fresh range, mostly
	// one that stays within the spread limit so the mean path is exercised.
	function automatic logic [SMP_W-1:0] next_sample(input logic [CH_W-1:0] ch);
		int r;
		if (chan_count[ch] == '0) begin
			r = $urandom_range(0, 9);
			if (r < 3) win_width[ch] = $urandom_range(0, 4095);
			else if (r < 5) win_width[ch] = int'(lim_reg);
			else win_width[ch] = $urandom_range(0, int'(lim_reg));
			r = $urandom_range(0, 9);
			if (r == 0) win_lo[ch] = 0;
			else if (r == 1) win_lo[ch] = 4095 - win_width[ch];
			else win_lo[ch] = $urandom_range(0, 4095 - win_width[ch]);
		end
		r = $urandom_range(0, 4);
		if (r == 0) return SMP_W'(win_lo[ch]);
		if (r == 1) return SMP_W'(win_lo[ch] + win_width[ch]);
		return SMP_W'(win_lo[ch] + $urandom_range(0, win_width[ch]));
	endfunction

	function automatic row_t smp_row(input logic [CH_W-1:0] ch, input logic [SMP_W-1:0] s);
		row_t r;
		r = '0;
		r.kind = ROW_SAMPLE;
		r.ch = ch;
		r.smp = s;
		return r;
	endfunction

	function automatic row_t end_row(input logic [CH_W-1:0] ch, input logic [SMP_W-1:0] s,
			input logic signed [MV_W-1:0] mv, input logic err);
		row_t r;
		r = smp_row(ch, s);
		r.typed = 1'b1;
		r.want.ch = ch;
		r.want.mv = mv;
		r.want.err = err;
		return r;
	endfunction

	function automatic row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		row_t r;
		r = '0;
		r.kind = ROW_CFG;
		r.idx = idx;
		r.data = data;
		return r;
	endfunction

	function automatic void note_mismatch(input string what, input int want, input int got);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS)
			$display("[%0t] %s: expected %0d, got %0d", $realtime, what, want, got);
	endfunction

	// Send one sample after a random gap (none while no_idle is set) and record what it should produce.
	task automatic send_sample(input logic [CH_W-1:0] ch, input logic [SMP_W-1:0] s,
			input bit typed, input mv_result_t want);
		int gap;
		bit produced;
		mv_result_t got;
		gap = no_idle ? 0 : $urandom_range(0, 9);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		channel <= ch;
		sample <= s;
		do @(posedge clk); while (in_stall);
		fold_sample(ch, s, produced, got);
		if (produced) pending_results.push_back(typed ? want : got);
	endtask

	// Hold off the sender until every expected result has come and the pipeline is empty.
	task automatic drain();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (RESULT_LATENCY + 4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data,
			input bit last);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		if (last) cfg_valid <= 1'b0;
		case (idx)
			CFG_SPREAD_LIMIT: lim_reg = data[LIM_W-1:0];
			CFG_REF_MV: ref_reg = data[REF_W-1:0];
			default: ;
		endcase
	endtask

	// Result side: stall for a random number of cycles, then take one item.
	initial begin
		int stall_len;
		out_stall <= 1'b0;
		@(posedge arst_n);
		forever begin
			stall_len = no_idle ? 0 : $urandom_range(0, 9);
			if (stall_len != 0) begin
				out_stall <= 1'b1;
				repeat (stall_len) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	// Compare each accepted result with the oldest expectation.
	always @(posedge clk) begin
		mv_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				note_mismatch("unexpected result on channel", -1, int'(result_channel));
			end else begin
				want = pending_results.pop_front();
				if (result_channel !== want.ch)
					note_mismatch("result_channel", int'(want.ch), int'(result_channel));
				if (value_mv !== want.mv)
					note_mismatch("value_mv", int'($signed(want.mv)), int'(value_mv));
				if (spread_error !== want.err)
					note_mismatch("spread_error", int'(want.err), int'(spread_error));
			end
		end
	end

	// Watchdog: too long without any item moving on any channel ends the run.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	initial begin
		logic [CH_W-1:0] ch;
		logic [CFG_DATA_W-1:0] lim_data;
		logic [CFG_DATA_W-1:0] ref_data;
		arst_n <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		in_valid <= 1'b0;
		channel <= '0;
		sample <= '0;
		no_idle = 1'b0;
		lim_reg = SPREAD_LIMIT_RST;
		ref_reg = REF_MV_RST;
		foreach (chan_count[i]) chan_count[i] = '0;

		// Writes to unmapped indexes must leave the defaults alone. Then three
		// interleaved windows: spread exactly at the default limit on channel 1,
		// full scale on channel 3, and a spread error on channel 2.
		dir_rows = '{
			cfg_row(CFG_UNMAPPED_2, 13'h1FFF),
			cfg_row(CFG_UNMAPPED_3, 13'h0AAA),
			smp_row(2'd1, 12'd100), smp_row(2'd3, 12'd4095), smp_row(2'd2, 12'd0),
			smp_row(2'd1, 12'd300), smp_row(2'd3, 12'd4095), smp_row(2'd2, 12'd4095),
			smp_row(2'd1, 12'd200), smp_row(2'd3, 12'd4095), smp_row(2'd2, 12'd2048),
			smp_row(2'd1, 12'd150), smp_row(2'd3, 12'd4095), smp_row(2'd2, 12'd1365),
			smp_row(2'd1, 12'd250), smp_row(2'd3, 12'd4095), smp_row(2'd2, 12'd2730),
			smp_row(2'd1, 12'd120), smp_row(2'd3, 12'd4095), smp_row(2'd2, 12'd1),
			smp_row(2'd1, 12'd280), smp_row(2'd3, 12'd4095), smp_row(2'd2, 12'd4094),
			smp_row(2'd1, 12'd200),
			end_row(2'd3, 12'd4095, 14'sd3300, 1'b0),
			end_row(2'd2, 12'd555, ERROR_MV, 1'b1)
		};

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_CFG) begin
				drain();
				write_reg(dir_rows[i].idx, dir_rows[i].data, 1'b1);
			end else begin
				send_sample(dir_rows[i].ch, dir_rows[i].smp, dir_rows[i].typed, dir_rows[i].want);
			end
		end

		// Random phases, each under its own register setting.
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			drain();
			lim_data = CFG_DATA_W'($urandom);
			ref_data = CFG_DATA_W'($urandom);
			case (ph)
				1: begin
					lim_data = '0;
					ref_data = 13'd5000;
				end
				2: begin
					lim_data = 13'h1FFF;
					ref_data = 13'h1FFF;
				end
				3: begin
					lim_data = CFG_DATA_W'($urandom_range(0, 400));
					ref_data = '0;
				end
				5: begin
					lim_data = CFG_DATA_W'($urandom_range(0, 4095));
					ref_data = 13'd1;
				end
				default: ;
			endcase
			if (ph != 0) begin
				write_reg(CFG_SPREAD_LIMIT, lim_data, 1'b0);
				write_reg(CFG_REF_MV, ref_data, 1'b1);
			end
			no_idle = (ph == 3);
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				// Halfway through phase 2, let every outstanding result drain before going on.
				if (ph == 2 && n == ITEMS_PER_PHASE / 2) drain();
				ch = CH_W'($urandom_range(0, NUM_CHANNELS - 1));
				send_sample(ch, next_sample(ch), 1'b0, '0);
			end
		end

		drain();
		if (mismatch_count == 0 && pending_results.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
